// ----- rtl/btnpwm_pkg.sv -----
`default_nettype none

package btnpwm_pkg;

  // register and field widths
  localparam int unsigned RegWidth    = 16;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CountWidthDef = 16;

  // register index map
  localparam logic [CfgIdxWidth-1:0] RegPwmPeriod    = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegDutyInitial  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegDutyStep     = 2'd2;
  localparam logic [CfgIdxWidth-1:0] RegDebounceTicks = 2'd3;

  // reset values
  localparam logic [RegWidth-1:0] PwmPeriodRst     = 16'd1000;
  localparam logic [RegWidth-1:0] DutyInitialRst   = 16'd500;
  localparam logic [RegWidth-1:0] DutyStepRst      = 16'd100;
  localparam logic [RegWidth-1:0] DebounceTicksRst = 16'd64;

endpackage

`default_nettype wire

// ----- rtl/button_stepped_pwm_dimmer.sv -----
`default_nettype none

// button stepped pwm dimmer
// one input request is one tick of the timer and carries the raw button pin
// level (0 pressed); each request yields exactly one result request holding
// the pwm drive bit, the debounced press indicator, the duty after this tick
// and the pwm running flag
// both channels use valid/stall; a request moves when valid is high and
// stall is low; the result sits in an output register from the cycle
// after its input request is taken; unless the receiver stalls,
// throughput is one tick per cycle: all button and counter work for a tick
// is one pass of logic between the state registers and the output register,
// and a new tick is taken while the output register drains in the same cycle
// when the receiver stalls, the held result stays put and in_stall_o rises,
// so no tick is taken until the result leaves
// reset loads the register defaults (period 1000, duty 500, step 100,
// debounce 64), clears the counters, starts pwm running and awaits a press
// config writes go through cfg_we_i / cfg_index_i / cfg_data_i while idle;
// a write of the initial duty loads the live duty too
module button_stepped_pwm_dimmer
  import btnpwm_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // config write port
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [RegWidth-1:0]    cfg_data_i,
  // tick input
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   button_level_i,
  // result output
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        pwm_level_o,
  output logic                        press_indicator_o,
  output logic [RegWidth-1:0]         duty_value_o,
  output logic                        pwm_running_o
);

  // compare width covers the counter plus its carry and the 16 bit registers
  localparam int unsigned CmpWidth = (COUNT_WIDTH + 1 > RegWidth + 1) ?
                                     COUNT_WIDTH + 1 : RegWidth + 1;

  // config registers
  logic [RegWidth-1:0] period_q, step_q, debounce_q;

  // tick state
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [RegWidth-1:0]    duty_q, duty_d;
  logic                   run_q, run_d;
  logic                   await_rel_q, await_rel_d;
  logic                   last_lvl_q;
  logic [COUNT_WIDTH-1:0] settle_q, settle_d;
  logic                   settle_act_q, settle_act_d;
  logic                   lamp_q, lamp_d;

  // output register
  logic                   out_valid_q;
  logic                   pwm_q, pwm_d;
  logic                   lamp_out_q;
  logic [RegWidth-1:0]    duty_out_q;
  logic                   run_out_q;

  logic                   in_accept;
  logic                   edge_det;
  logic                   press_ok;
  logic                   stop_now;
  logic [RegWidth:0]      duty_sum;
  logic [COUNT_WIDTH:0]   count_inc;
  logic [COUNT_WIDTH-1:0] count_mid;

  // output register can take a tick unless it holds a stalled result
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // a step fits when duty + step stays within the period
  assign duty_sum = {1'b0, duty_q} + {1'b0, step_q};
  assign press_ok = duty_sum <= {1'b0, period_q};

  always_comb begin
    await_rel_d  = await_rel_q;
    settle_d     = settle_q;
    settle_act_d = settle_act_q;
    lamp_d       = lamp_q;
    duty_d       = duty_q;
    run_d        = run_q;
    stop_now     = 1'b0;

    // only the awaited edge restarts the debounce countdown
    if (await_rel_q) begin
      edge_det = ~last_lvl_q & button_level_i;
    end else begin
      edge_det = last_lvl_q & ~button_level_i;
    end

    if (edge_det) begin
      settle_d     = COUNT_WIDTH'(debounce_q);
      settle_act_d = 1'b1;
    end else if (settle_act_q) begin
      if (settle_q > COUNT_WIDTH'(1)) begin
        settle_d = settle_q - COUNT_WIDTH'(1);
      end else begin
        // countdown done: sample the pin
        settle_d     = '0;
        settle_act_d = 1'b0;
        if (!button_level_i && !await_rel_q) begin
          await_rel_d = 1'b1;
          lamp_d      = 1'b1;
          if (press_ok) begin
            duty_d = duty_sum[RegWidth-1:0];
            run_d  = 1'b1;
          end else begin
            // duty would overshoot: stop pwm with output low
            duty_d   = '0;
            run_d    = 1'b0;
            stop_now = 1'b1;
          end
        end else if (button_level_i && await_rel_q) begin
          await_rel_d = 1'b0;
          lamp_d      = 1'b0;
        end
      end
    end

    // pwm output from the current count and the updated duty, then advance
    count_mid = stop_now ? '0 : count_q;
    count_inc = {1'b0, count_mid} + {{COUNT_WIDTH{1'b0}}, 1'b1};
    pwm_d     = 1'b0;
    count_d   = count_mid;
    if (run_d) begin
      pwm_d = CmpWidth'(count_mid) < CmpWidth'(duty_d);
      if (CmpWidth'(count_inc) >= CmpWidth'(period_q)) begin
        count_d = '0;
      end else begin
        count_d = count_inc[COUNT_WIDTH-1:0];
      end
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PwmPeriodRst;
      step_q      <= DutyStepRst;
      debounce_q  <= DebounceTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegPwmPeriod:     period_q    <= cfg_data_i;
        // only the live duty keeps this value
        RegDutyInitial:   ;
        RegDutyStep:      step_q      <= cfg_data_i;
        RegDebounceTicks: debounce_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // tick state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      duty_q       <= DutyInitialRst;
      run_q        <= 1'b1;
      await_rel_q  <= 1'b0;
      last_lvl_q   <= 1'b1;
      settle_q     <= '0;
      settle_act_q <= 1'b0;
      lamp_q       <= 1'b0;
    end else begin
      if (in_accept) begin
        count_q      <= count_d;
        run_q        <= run_d;
        await_rel_q  <= await_rel_d;
        last_lvl_q   <= button_level_i;
        settle_q     <= settle_d;
        settle_act_q <= settle_act_d;
        lamp_q       <= lamp_d;
      end
      // writing the initial duty also loads the live duty
      if (cfg_we_i && cfg_index_i == RegDutyInitial) begin
        duty_q <= cfg_data_i;
      end else if (in_accept) begin
        duty_q <= duty_d;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pwm_q      <= pwm_d;
      lamp_out_q <= lamp_d;
      duty_out_q <= duty_d;
      run_out_q  <= run_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign pwm_level_o       = pwm_q;
  assign press_indicator_o = lamp_out_q;
  assign duty_value_o      = duty_out_q;
  assign pwm_running_o     = run_out_q;

  // a stopped pwm never drives high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !pwm_running_o) |-> !pwm_level_o)
    else $error("pwm high while stopped");

  // the counter sits at zero while stopped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q |-> (count_q == '0))
    else $error("pwm count moved while stopped");

  // an idle debounce has no countdown left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !settle_act_q |-> (settle_q == '0))
    else $error("settle count left over");

  // a result taken with no new tick empties the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !in_valid_i) |=> !out_valid_o)
    else $error("result repeated");

  // a drained output register never stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

`default_nettype wire

// ----- tb/button_stepped_pwm_dimmer_tb.sv -----
`timescale 1ns / 100ps

module button_stepped_pwm_dimmer_tb;
  import btnpwm_pkg::*;

  // one result request as seen on the output side
  typedef struct packed {
    logic                pwm;
    logic                lamp;
    logic [RegWidth-1:0] duty;
    logic                running;
  } dimmer_out_t;

  // tracks the dimmer state tick by tick and holds the results still owed
  class dimmer_scoreboard;
    int unsigned period, duty_init, step, debounce;
    int unsigned count, duty, settle;
    bit running, await_release, last_level, settling, lamp;
    dimmer_out_t pending_q[$];
    int unsigned ticks, checked, errors;

    function new();
      period = 32'(PwmPeriodRst);
      duty_init = 32'(DutyInitialRst);
      step = 32'(DutyStepRst);
      debounce = 32'(DebounceTicksRst);
      count = 0;
      duty = 32'(DutyInitialRst);
      settle = 0;
      running = 1'b1;
      await_release = 1'b0;
      last_level = 1'b1;
      settling = 1'b0;
      lamp = 1'b0;
    endfunction

    function void write_reg(logic [CfgIdxWidth-1:0] idx, logic [RegWidth-1:0] val);
      case (idx)
        RegPwmPeriod: period = 32'(val);
        RegDutyInitial: begin
          // live duty follows the initial duty at once
          duty_init = 32'(val);
          duty = 32'(val);
        end
        RegDutyStep: step = 32'(val);
        RegDebounceTicks: debounce = 32'(val);
        default: ;
      endcase
    endfunction

    // advance the dimmer by one accepted tick and queue its result
    function void note_tick(bit level);
      bit edge_seen;
      bit pwm_out;
      dimmer_out_t res;
      pwm_out = 1'b0;
      if (await_release) edge_seen = !last_level && level;
      else edge_seen = last_level && !level;
      last_level = level;

      if (edge_seen) begin
        settle = debounce;
        settling = 1'b1;
      end else if (settling) begin
        if (settle > 1) begin
          settle = settle - 1;
        end else begin
          settle = 0;
          settling = 1'b0;
          if (!level && !await_release) begin
            await_release = 1'b1;
            lamp = 1'b1;
            if (period >= step && duty <= period - step) begin
              duty = duty + step;
              running = 1'b1;
            end else begin
              duty = 0;
              running = 1'b0;
              count = 0;
            end
          end else if (level && await_release) begin
            await_release = 1'b0;
            lamp = 1'b0;
          end
        end
      end

      if (running) begin
        pwm_out = count < duty;
        if (count + 1 >= period) count = 0;
        else count = count + 1;
      end

      res.pwm = pwm_out;
      res.lamp = lamp;
      res.duty = duty[RegWidth-1:0];
      res.running = running;
      pending_q.push_back(res);
      ticks++;
    endfunction

    function void check_result(dimmer_out_t got);
      dimmer_out_t want;
      if (pending_q.size() == 0) begin
        $error("result request with no tick pending");
        errors++;
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got.pwm !== want.pwm) begin
        $error("pwm_level: expected %0d, actual %0d", want.pwm, got.pwm);
        errors++;
      end
      if (got.lamp !== want.lamp) begin
        $error("press_indicator: expected %0d, actual %0d", want.lamp, got.lamp);
        errors++;
      end
      if (got.duty !== want.duty) begin
        $error("duty_value: expected %0d, actual %0d", want.duty, got.duty);
        errors++;
      end
      if (got.running !== want.running) begin
        $error("pwm_running: expected %0d, actual %0d", want.running, got.running);
        errors++;
      end
    endfunction
  endclass

  // clock, reset and block inputs, all known from time zero
  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index_i = RegPwmPeriod;
  logic [RegWidth-1:0]    cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic                   button_level_i = 1'b1;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic                   pwm_level_o;
  logic                   press_indicator_o;
  logic [RegWidth-1:0]    duty_value_o;
  logic                   pwm_running_o;

  dimmer_scoreboard sb;

  // idle odds in percent, changed per phase
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned settings_seen = 0;

  // press sequence for the directed part: a clean press and release, a bouncy
  // press, a release that bounces back low, then presses up to full duty and
  // one more that stops the pwm
  localparam bit [26:0] DirectedLevels = 27'b10011_01001011_0011_0011_0011_00;

  button_stepped_pwm_dimmer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .button_level_i   (button_level_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pwm_level_o      (pwm_level_o),
    .press_indicator_o(press_indicator_o),
    .duty_value_o     (duty_value_o),
    .pwm_running_o    (pwm_running_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver stall, redrawn every cycle
  always @(posedge clk_i) begin
    out_stall_i <= (rx_stall_pct != 0) && ($urandom_range(0, 99) < rx_stall_pct);
  end

  // result monitor: check every result request that leaves the block
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result({pwm_level_o, press_indicator_o, duty_value_o, pwm_running_o});
    end
  end

  // pick the idle pattern for a phase: none, sender, receiver, both
  task automatic set_idle(int unsigned phase);
    case (phase % 4)
      0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
      1: begin tx_idle_pct = 48; rx_stall_pct = 0; end
      2: begin tx_idle_pct = 0; rx_stall_pct = 48; end
      default: begin tx_idle_pct = 32; rx_stall_pct = 32; end
    endcase
  endtask

  // offer one tick and wait until it is taken; entered and left at a rising edge
  task automatic send_tick(bit level);
    int unsigned gap;
    gap = 0;
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct && gap < 20) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    button_level_i <= level;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_tick(level);
  endtask

  // let every owed result drain, then the output register latency
  task automatic wait_drain();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxWidth-1:0] idx, logic [RegWidth-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // only called with the block idle and in_valid low
  task automatic configure(int unsigned period, int unsigned duty, int unsigned step,
                           int unsigned debounce);
    cfg_write(RegPwmPeriod, period[RegWidth-1:0]);
    cfg_write(RegDutyInitial, duty[RegWidth-1:0]);
    cfg_write(RegDutyStep, step[RegWidth-1:0]);
    cfg_write(RegDebounceTicks, debounce[RegWidth-1:0]);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings_seen++;
  endtask

  // mostly full press/release cycles with random hold times (some cut short by
  // one tick so the sample misses), plus bounces and bursts of random levels
  task automatic run_random(int unsigned budget, bit drain_midway);
    int unsigned sent, hold, deb;
    bit paused;
    sent = 0;
    paused = 1'b0;
    deb = (sb.debounce == 0) ? 1 : sb.debounce;
    while (sent < budget) begin
      if (drain_midway && !paused && sent >= budget / 2) begin
        // sender holds off until nothing is owed
        paused = 1'b1;
        in_valid_i <= 1'b0;
        wait_drain();
      end
      if (deb <= 200 && $urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 2) == 0) begin
          send_tick(1'b0);
          send_tick(1'b1);
          sent += 2;
        end
        hold = $urandom_range(deb, deb + 3);
        repeat (hold) send_tick(1'b0);
        sent += hold;
        if ($urandom_range(0, 2) == 0) begin
          send_tick(1'b1);
          send_tick(1'b0);
          sent += 2;
        end
        hold = $urandom_range(deb, deb + 3);
        repeat (hold) send_tick(1'b1);
        sent += hold;
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_tick(1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end
    in_valid_i <= 1'b0;
  endtask

  // run limit
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned p;
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults, no register written yet
    set_idle(0);
    run_random(40, 1'b0);
    wait_drain();

    // short period, unit step: directed presses up to full duty and the stop
    configure(4, 0, 1, 1);
    set_idle(1);
    for (int i = 26; i >= 0; i--) send_tick(DirectedLevels[i]);
    run_random(40, 1'b0);
    wait_drain();

    // all-ones registers: full duty at start, any press stops the pwm
    configure(65535, 65535, 65535, 2);
    set_idle(2);
    run_random(40, 1'b0);
    wait_drain();

    // single-tick period
    configure(1, 0, 1, 3);
    set_idle(3);
    run_random(50, 1'b0);
    wait_drain();

    // zero period and zero debounce
    configure(0, 5, 3, 0);
    set_idle(0);
    run_random(50, 1'b0);
    wait_drain();

    // duty above period, sender pauses midway until drained
    configure(10, 12, 3, 4);
    set_idle(1);
    run_random(50, 1'b1);
    wait_drain();

    // longest debounce: countdowns start but never finish
    configure(17, 16, 16, 65535);
    set_idle(2);
    run_random(30, 1'b0);
    wait_drain();

    // random small settings
    for (int k = 0; k < 4; k++) begin
      p = $urandom_range(2, 40);
      configure(p, $urandom_range(0, p + 5), $urandom_range(1, 12), $urandom_range(1, 6));
      set_idle(3 + k);
      run_random(25, k == 1);
      wait_drain();
    end

    repeat (5) @(posedge clk_i);
    $display("dimmer run: %0d ticks sent, %0d results checked, %0d register settings",
             sb.ticks, sb.checked, settings_seen + 1);
    $display("idle patterns: none, sender gaps, receiver stalls, both");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
